@@ hdl/shpc_pkg.sv @@
// Shared types and constants for the stepper homing position controller.
package shpc_pkg;

	localparam int SLOT_MAX     = 5;
	localparam int POS_W        = 16;
	localparam int TICK_W       = 8;
	localparam int POLL_W       = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int OPCODE_W     = 2;
	localparam int SLOT_IDX_W   = 3;

	localparam int DEF_SLOT_COUNT    = 5;
	localparam int DEF_POLL_STEPS    = 50;
	localparam int DEF_POSITION_BITS = 16;

	localparam logic [POS_W-1:0] SLOT_RESET [SLOT_MAX] = '{
		16'd4000, 16'd12000, 16'd20000, 16'd28000, 16'd36000
	};
	localparam logic [TICK_W-1:0] HOMING_TICKS_RESET = 8'd2;
	localparam logic [TICK_W-1:0] MOVE_TICKS_RESET   = 8'd1;
	localparam logic [POS_W-1:0]  BACKOFF_RESET      = 16'd200;

	// configuration register indexes; slots occupy indexes 0 to SLOT_MAX-1
	localparam logic [CFG_IDX_W-1:0] REG_HOMING_TICKS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_TICKS   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF      = 3'd7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK    = 2'd0,
		OP_HOME    = 2'd1,
		OP_MOVE    = 2'd2,
		OP_DISABLE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_SEEK    = 2'd1,
		MODE_BACKOFF = 2'd2,
		MODE_MOVE    = 2'd3
	} mode_t;

	typedef struct packed {
		logic             step_pulse;
		logic             direction;
		logic             driver_on;
		logic [POS_W-1:0] position;
		logic             busy_res;
		logic             aborted;
		logic             finished;
	} result_t;

	function automatic logic [TICK_W-1:0] reload_of(input logic [TICK_W-1:0] ticks);
		return (ticks == '0) ? '0 : ticks - TICK_W'(1);
	endfunction

endpackage

@@ hdl/stepper_homing_position_controller_top.sv @@
// Step/direction stepper controller with homing: one item in, one result out.
//
// Items arrive on in_valid/in_stall: opcode (tick, home, move to slot,
// disable), slot_index, limit_hit and estop_active. Each accepted item yields
// exactly one result on out_valid/out_stall: step_pulse, direction,
// driver_on, position, busy_res, aborted and finished.
// An accepted item's result is registered in the result register, or in the
// skid register while a result waits. One item can be accepted every cycle
// while in_stall is low; the whole update is done in the cycle of transfer.
// A skid register behind the result register lets the block take one more
// item while a result waits; in_stall rises only when both hold results.
// Configuration uses cfg_valid/cfg_ready with cfg_index and cfg_data and is
// always ready; write only while the block is idle.
// Reset (arst_n low) empties both result registers, returns the controller
// to idle with position zero and the driver off, and loads the default
// slot positions, step intervals and back-off count.
module stepper_homing_position_controller_top #(
	parameter int SLOT_COUNT    = shpc_pkg::DEF_SLOT_COUNT,
	parameter int POLL_STEPS    = shpc_pkg::DEF_POLL_STEPS,
	parameter int POSITION_BITS = shpc_pkg::DEF_POSITION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [shpc_pkg::OPCODE_W-1:0]   opcode,
	input  logic [shpc_pkg::SLOT_IDX_W-1:0] slot_index,
	input  logic                            limit_hit,
	input  logic                            estop_active,
	// result output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            step_pulse,
	output logic                            direction,
	output logic                            driver_on,
	output logic [shpc_pkg::POS_W-1:0]      position,
	output logic                            busy_res,
	output logic                            aborted,
	output logic                            finished,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [shpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [shpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import shpc_pkg::*;

	localparam int SIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// configuration registers
	logic [POS_W-1:0]  slot_pos_q [SLOT_COUNT];
	logic [TICK_W-1:0] homing_ticks_q;
	logic [TICK_W-1:0] move_ticks_q;
	logic [POS_W-1:0]  backoff_count_q;

	// controller state
	mode_t                    mode_q, mode_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [POSITION_BITS-1:0] target_q, target_n;
	logic                     dir_q, dir_n;
	logic                     drv_q, drv_n;
	logic [TICK_W-1:0]        cnt_q, cnt_n;
	logic [POLL_W-1:0]        poll_q, poll_n;
	logic [POS_W-1:0]         backoff_q, backoff_n;

	result_t res_n;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    in_fire, out_fire, out_load, skid_load;

	logic [POS_W-1:0]  slot_sel;
	logic              pulse, abrt, fin;
	logic [POLL_W-1:0] poll_inc;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_fire   = in_valid && !skid_valid_q;
	assign out_fire  = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_pos_q[i] <= SLOT_RESET[i];
			end
			homing_ticks_q  <= HOMING_TICKS_RESET;
			move_ticks_q    <= MOVE_TICKS_RESET;
			backoff_count_q <= BACKOFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HOMING_TICKS: homing_ticks_q  <= cfg_data[TICK_W-1:0];
				REG_MOVE_TICKS:   move_ticks_q    <= cfg_data[TICK_W-1:0];
				REG_BACKOFF:      backoff_count_q <= cfg_data;
				default: begin
					if (32'(cfg_index) < SLOT_COUNT) begin
						slot_pos_q[cfg_index[SIW-1:0]] <= cfg_data;
					end
				end
			endcase
		end
	end

	assign slot_sel = slot_pos_q[slot_index[SIW-1:0]];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			pos_q     <= '0;
			target_q  <= '0;
			dir_q     <= 1'b0;
			drv_q     <= 1'b0;
			cnt_q     <= '0;
			poll_q    <= '0;
			backoff_q <= '0;
		end else if (in_fire) begin
			mode_q    <= mode_n;
			pos_q     <= pos_n;
			target_q  <= target_n;
			dir_q     <= dir_n;
			drv_q     <= drv_n;
			cnt_q     <= cnt_n;
			poll_q    <= poll_n;
			backoff_q <= backoff_n;
		end
	end

	// next state and result for the item at the input
	always_comb begin
		mode_n    = mode_q;
		pos_n     = pos_q;
		target_n  = target_q;
		dir_n     = dir_q;
		drv_n     = drv_q;
		cnt_n     = cnt_q;
		poll_n    = poll_q;
		backoff_n = backoff_q;
		pulse     = 1'b0;
		abrt      = 1'b0;
		fin       = 1'b0;
		poll_inc  = poll_q + POLL_W'(1);

		if (opcode == OP_TICK) begin
			if (mode_q != MODE_IDLE) begin
				if (cnt_q != '0) begin
					cnt_n = cnt_q - TICK_W'(1);
				end else if (mode_q == MODE_SEEK) begin
					if (limit_hit) begin
						mode_n    = MODE_BACKOFF;
						dir_n     = 1'b1;
						backoff_n = backoff_count_q;
					end else begin
						pulse  = 1'b1;
						cnt_n  = reload_of(homing_ticks_q);
						poll_n = poll_inc;
					end
				end else if (mode_q == MODE_MOVE) begin
					if (pos_q == target_q) begin
						mode_n = MODE_IDLE;
						fin    = 1'b1;
					end else begin
						pulse  = 1'b1;
						pos_n  = dir_q ? pos_q + POSITION_BITS'(1)
						               : pos_q - POSITION_BITS'(1);
						cnt_n  = reload_of(move_ticks_q);
						poll_n = poll_inc;
					end
				end
				// e-stop is sampled on every POLL_STEPS-th seek or move step
				if (pulse && poll_inc >= POLL_W'(POLL_STEPS)) begin
					poll_n = '0;
					if (estop_active) begin
						drv_n  = 1'b0;
						mode_n = MODE_IDLE;
						abrt   = 1'b1;
					end
				end
				if (mode_n == MODE_BACKOFF && cnt_n == '0 && !pulse) begin
					if (backoff_n == '0) begin
						pos_n  = '0;
						dir_n  = 1'b0;
						mode_n = MODE_IDLE;
						fin    = 1'b1;
					end else begin
						pulse     = 1'b1;
						backoff_n = backoff_n - POS_W'(1);
						cnt_n     = reload_of(homing_ticks_q);
					end
				end
			end
		end else if (mode_q == MODE_IDLE) begin
			unique case (opcode)
				OP_HOME: begin
					drv_n  = 1'b1;
					dir_n  = 1'b0;
					mode_n = MODE_SEEK;
					cnt_n  = '0;
					poll_n = '0;
				end
				OP_MOVE: begin
					if (32'(slot_index) < SLOT_COUNT) begin
						target_n = POSITION_BITS'(slot_sel);
						drv_n    = 1'b1;
						dir_n    = target_n > pos_q;
						cnt_n    = '0;
						poll_n   = '0;
						if (target_n == pos_q) begin
							fin = 1'b1;
						end else begin
							mode_n = MODE_MOVE;
						end
					end
				end
				OP_DISABLE: drv_n = 1'b0;
				default:    ;
			endcase
		end

		res_n.step_pulse = pulse;
		res_n.direction  = dir_n;
		res_n.driver_on  = drv_n;
		res_n.position   = POS_W'(pos_n);
		res_n.busy_res   = mode_n != MODE_IDLE;
		res_n.aborted    = abrt;
		res_n.finished   = fin;
	end

	// result register with skid stage
	assign out_load  = !out_valid_q || out_fire;
	assign skid_load = in_fire && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (skid_load) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : res_n;
		end
		if (skid_load) begin
			skid_q <= res_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign step_pulse = out_q.step_pulse;
	assign direction  = out_q.direction;
	assign driver_on  = out_q.driver_on;
	assign position   = out_q.position;
	assign busy_res   = out_q.busy_res;
	assign aborted    = out_q.aborted;
	assign finished   = out_q.finished;

	// a waiting skid entry always sits behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without result entry");

	// an abort leaves the driver off and the block idle
	a_abort_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.aborted) |-> (!out_q.driver_on && !out_q.busy_res))
		else $error("abort left driver on or run busy");

	// a run never both completes and aborts on one item
	a_abort_xor_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.aborted && out_q.finished))
		else $error("aborted and finished together");

	// a finished homing or move returns to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && fin) |=> (mode_q == MODE_IDLE))
		else $error("finished item left the controller busy");

endmodule
